/* sv/frt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frt_pkg
// types and constants shared by the fragment reassembly tracker
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [15:0] SIZE_RESET = 16'd1500;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_BAD_INDEX = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_CAPACITY  = 3'd5;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_BYTE   = 1'b1;

    localparam logic [1:0] REG_MAX_SIZE = 2'd0;
    localparam logic [1:0] REG_STREAMS  = 2'd1;

    typedef struct packed {
        logic [2:0]  stream;
        logic [15:0] index;
        logic [15:0] count;
        logic [15:0] size;
        logic [31:0] crc;
    } header_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int j = 0; j < 8; j++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/fragment_reassembly_tracker_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_core
// judges fragments by size, index, capacity, crc-32 and duplicate bitmap per stream
// ----------------------------------------------------------------------------
// Input channel s_*: a header transaction (operation 0) followed by
// payload-length payload byte transactions (operation 1). Payload bytes are
// taken one per cycle; the crc is updated as each byte arrives.
// A verdict appears on m_* for the last byte, or for the header itself when
// the fragment is empty. Judging then runs through a bitmap memory read, a
// decide step and the write back of bitmap and per-stream counters. Input
// is held off during those steps.
// The result sits in an output register; the block stalls in the write back
// state while a previous result has not been taken by the receiver.
// After reset the bitmap memory is cleared one word per cycle, all
// (MAX_STREAMS*MAX_FRAGS+31)/32 words, while s_ready stays low. APB writes are
// taken at any time and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_core
    import frt_pkg::*;
#(
    parameter int MAX_STREAMS = 8,
    parameter int MAX_FRAGS   = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [2:0]  s_stream,
    input  wire logic [15:0] s_fragment_index,
    input  wire logic [15:0] s_fragment_count,
    input  wire logic [15:0] s_payload_length,
    input  wire logic [31:0] s_data_crc,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [2:0]       m_result_stream,
    output logic [15:0]      m_result_index,
    output logic [31:0]      m_computed_crc,
    output logic [15:0]      m_received_count,
    output logic [31:0]      m_stream_bytes,
    output logic             m_all_done
);

    localparam int BITS    = MAX_STREAMS * MAX_FRAGS;
    localparam int WORDS   = (BITS + 31) / 32;
    localparam int WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FAW     = $clog2(MAX_FRAGS);
    localparam int SAW     = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int BAW     = $clog2(BITS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_JUDGE = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [15:0] max_size_reg;
    logic [3:0]  streams_reg;
    header_t     hdr_reg;
    logic [31:0] crc_reg;
    logic [15:0] left_reg;
    logic [WAW-1:0] clr_reg;

    logic [31:0] map_mem [WORDS];
    logic [31:0] map_rd_reg;
    logic [15:0] acc_reg [MAX_STREAMS];
    logic [15:0] exp_reg [MAX_STREAMS];
    logic [31:0] tot_reg [MAX_STREAMS];

    logic [2:0]  status_reg;
    logic        out_valid_reg;
    logic [2:0]  o_status_reg;
    logic [2:0]  o_stream_reg;
    logic [15:0] o_index_reg;
    logic [31:0] o_crc_reg;
    logic [15:0] o_count_reg;
    logic [31:0] o_bytes_reg;
    logic        o_done_reg;

    logic            s_fire;
    logic            trigger;
    logic [BAW-1:0]  bit_pos;
    logic [WAW-1:0]  word_addr;
    logic [4:0]      bit_sel;
    logic            in_range;
    logic [SAW-1:0]  sidx;
    logic [15:0]     acc_new;
    logic [31:0]     tot_new;
    logic [32:0]     tot_sum;
    logic            done_flag;
    logic [4:0]      n_act;
    logic [31:0]     crc_final;

    assign pready = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign s_fire = s_valid && s_ready;

    always_comb begin
        case (paddr[2])
            REG_MAX_SIZE[0]: prdata = {16'd0, max_size_reg};
            default:         prdata = {28'd0, streams_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= SIZE_RESET;
            streams_reg  <= 4'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MAX_SIZE[0]) begin
                max_size_reg <= pwdata[15:0];
            end else if (paddr[2] == REG_STREAMS[0]) begin
                streams_reg <= pwdata[3:0];
            end
        end
    end

    // header latch and crc
    assign trigger = s_fire && ((s_operation == OP_HEADER && s_payload_length == 16'd0)
                     || (s_operation == OP_BYTE && left_reg == 16'd1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            crc_reg  <= '0;
            hdr_reg  <= '0;
        end else if (s_fire) begin
            if (s_operation == OP_HEADER) begin
                hdr_reg  <= '{s_stream, s_fragment_index, s_fragment_count,
                              s_payload_length, s_data_crc};
                crc_reg  <= CRC_INIT;
                left_reg <= s_payload_length;
            end else if (left_reg != 16'd0) begin
                crc_reg  <= crc_byte(crc_reg, s_data_byte);
                left_reg <= left_reg - 16'd1;
            end
        end
    end

    assign in_range  = ({13'd0, hdr_reg.stream} < 16'(MAX_STREAMS))
                       && ({1'b0, hdr_reg.index} <= 17'(MAX_FRAGS));
    assign sidx      = SAW'(hdr_reg.stream);
    assign bit_pos   = BAW'(32'(sidx) * 32'(MAX_FRAGS) + 32'(FAW'(hdr_reg.index - 16'd1)));
    assign word_addr = WAW'(bit_pos >> 5);
    assign bit_sel   = 5'(bit_pos);
    assign crc_final = ~crc_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (32'(clr_reg) == WORDS - 1) state_next = S_IDLE;
            S_IDLE:  if (trigger) state_next = S_READ;
            S_READ:  state_next = S_JUDGE;
            S_JUDGE: state_next = S_WRITE;
            S_WRITE: if (!out_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + WAW'(1);
        end
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            map_mem[clr_reg] <= '0;
        end else if (state_reg == S_WRITE && state_next == S_IDLE
                     && status_reg == ST_ACCEPTED) begin
            map_mem[word_addr] <= map_rd_reg | (32'd1 << bit_sel);
        end
        map_rd_reg <= map_mem[word_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_JUDGE) begin
            if (hdr_reg.size > max_size_reg) status_reg <= ST_TOO_LARGE;
            else if (hdr_reg.index == 16'd0 || hdr_reg.index > hdr_reg.count)
                status_reg <= ST_BAD_INDEX;
            else if (!in_range) status_reg <= ST_CAPACITY;
            else if (crc_final != hdr_reg.crc) status_reg <= ST_CRC_ERROR;
            else if (map_rd_reg[bit_sel]) status_reg <= ST_DUPLICATE;
            else status_reg <= ST_ACCEPTED;
        end
    end

    assign acc_new = (acc_reg[sidx] == 16'hFFFF) ? acc_reg[sidx] : acc_reg[sidx] + 16'd1;
    assign tot_sum = {1'b0, tot_reg[sidx]} + {17'd0, hdr_reg.size};
    assign tot_new = tot_sum[32] ? 32'hFFFFFFFF : tot_sum[31:0];
    assign n_act   = (streams_reg == 4'd0) ? 5'd1
                   : ({1'b0, streams_reg} > 5'(MAX_STREAMS)) ? 5'(MAX_STREAMS)
                   : {1'b0, streams_reg};

    always_comb begin
        done_flag = 1'b1;
        for (int i = 0; i < MAX_STREAMS; i++) begin
            if (5'(i) < n_act) begin
                if (status_reg == ST_ACCEPTED && SAW'(i) == sidx) begin
                    if (hdr_reg.count == 16'd0 || acc_new < hdr_reg.count) done_flag = 1'b0;
                end else if (exp_reg[i] == 16'd0 || acc_reg[i] < exp_reg[i]) begin
                    done_flag = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_STREAMS; i++) begin
                acc_reg[i] <= '0;
                exp_reg[i] <= '0;
                tot_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_WRITE && state_next == S_IDLE) begin
                out_valid_reg <= 1'b1;
                o_status_reg  <= status_reg;
                o_stream_reg  <= hdr_reg.stream;
                o_index_reg   <= hdr_reg.index;
                o_crc_reg     <= crc_final;
                o_done_reg    <= done_flag;
                if (status_reg == ST_ACCEPTED) begin
                    acc_reg[sidx] <= acc_new;
                    tot_reg[sidx] <= tot_new;
                    exp_reg[sidx] <= hdr_reg.count;
                    o_count_reg   <= acc_new;
                    o_bytes_reg   <= tot_new;
                end else if ({13'd0, hdr_reg.stream} < 16'(MAX_STREAMS)) begin
                    o_count_reg <= acc_reg[sidx];
                    o_bytes_reg <= tot_reg[sidx];
                end else begin
                    o_count_reg <= '0;
                    o_bytes_reg <= '0;
                end
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = o_status_reg;
    assign m_result_stream  = o_stream_reg;
    assign m_result_index   = o_index_reg;
    assign m_computed_crc   = o_crc_reg;
    assign m_received_count = o_count_reg;
    assign m_stream_bytes   = o_bytes_reg;
    assign m_all_done       = o_done_reg;

`ifndef ASSERT_OFF
    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !s_ready) else $error("input taken while judging");
    a_read_follows_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        trigger |=> (state_reg == S_READ)) else $error("verdict not started");
    a_result_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_WRITE)) else $error("stray result");
`endif

endmodule
`default_nettype wire
